FILE: src/chs_pkg.sv
package chs_pkg;

  // heading units: 1/16 degree at the ports, 1/4096 degree in the state
  localparam int FullIn    = 5760;
  localparam int FullSt    = 1474560;
  localparam int HalfSt    = 737280;
  localparam int SectHalf  = 360;
  localparam int SectSpan  = 720;
  localparam int RoundBias = 32768;

  localparam logic [15:0] GainReset = 16'd6554;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_LOAD,
    OP_UPDATE
  } chs_op_e;

  typedef enum logic [1:0] {
    CFG_DECL       = 2'd0,
    CFG_DECL_VALID = 2'd1,
    CFG_VIEW_TRUE  = 2'd2,
    CFG_GAIN       = 2'd3
  } chs_cfg_idx_e;

  typedef struct packed {
    logic [12:0] raw_heading;
    logic        mag_valid;
  } chs_in_t;

  typedef struct packed {
    logic        heading_valid;
    logic [12:0] smoothed_mag;
    logic [12:0] geo_heading;
    logic        true_valid;
    logic [12:0] shown_heading;
    logic        shown_is_true;
    logic [2:0]  sector;
  } chs_out_t;

  typedef struct packed {
    logic signed [12:0] decl;
    logic               decl_valid;
    logic               view_true;
    logic [15:0]        gain;
  } chs_cfg_t;

  // queued command: classified and range-reduced sample
  typedef struct packed {
    chs_op_e     op;
    logic [12:0] heading;
  } chs_cmd_t;

  // state-update stage to output stage
  typedef struct packed {
    logic        hv;
    logic [20:0] st;
  } chs_stage_t;

endpackage

FILE: src/chs_front.sv
module chs_front import chs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  chs_in_t  in_item_i,
  output logic     push_o,
  input  logic     push_ready_i,
  output chs_cmd_t cmd_o
);

  logic loaded_q, loaded_d;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i & push_ready_i;

  always_comb begin
    if (!in_item_i.mag_valid) begin
      cmd_o.op = OP_SKIP;
    end else if (loaded_q) begin
      cmd_o.op = OP_UPDATE;
    end else begin
      cmd_o.op = OP_LOAD;
    end
    if (in_item_i.raw_heading >= 13'(FullIn)) begin
      cmd_o.heading = in_item_i.raw_heading - 13'(FullIn);
    end else begin
      cmd_o.heading = in_item_i.raw_heading;
    end
  end

  // first valid sample seeds the average, so the front tracks it itself
  assign loaded_d = loaded_q | (push_o & in_item_i.mag_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else begin
      loaded_q <= loaded_d;
    end
  end

endmodule

FILE: src/chs_fifo.sv
module chs_fifo import chs_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     push_ready_o,
  input  chs_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_i,
  output chs_cmd_t pop_data_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  chs_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/chs_back.sv
module chs_back import chs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chs_cfg_t   cfg_i,
  input  logic       cmd_valid_i,
  output logic       cmd_pop_o,
  input  chs_cmd_t   cmd_i,
  output logic       stage_valid_o,
  input  logic       stage_ready_i,
  output chs_stage_t stage_o
);

  localparam logic signed [21:0] HalfS  = 22'(HalfSt);
  localparam logic signed [21:0] FullS  = 22'(FullSt);
  localparam logic signed [22:0] FullS3 = 23'(FullSt);

  logic [20:0]        state_q, state_d;
  logic               valid_q, valid_d;
  chs_stage_t         stage_q, stage_d;
  logic [20:0]        hs;
  logic signed [21:0] diff, dfold;
  logic signed [20:0] d21;
  logic signed [37:0] prod, prod_rnd;
  logic signed [21:0] step;
  logic signed [22:0] sum, sum_w;

  assign cmd_pop_o = cmd_valid_i & (~valid_q | stage_ready_i);

  assign hs   = {cmd_i.heading, 8'd0};
  assign diff = $signed({1'b0, hs}) - $signed({1'b0, state_q});

  // shortest way round: fold into -180..+180 degrees
  always_comb begin
    if (diff < -HalfS) begin
      dfold = diff + FullS;
    end else if (diff > HalfS) begin
      dfold = diff - FullS;
    end else begin
      dfold = diff;
    end
  end

  assign d21      = dfold[20:0];
  assign prod     = d21 * $signed({1'b0, cfg_i.gain});
  assign prod_rnd = prod + 38'(RoundBias);
  assign step     = prod_rnd[37:16];
  assign sum      = $signed({2'b00, state_q}) + $signed({step[21], step});

  always_comb begin
    if (sum < 0) begin
      sum_w = sum + FullS3;
    end else if (sum >= FullS3) begin
      sum_w = sum - FullS3;
    end else begin
      sum_w = sum;
    end
  end

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    valid_d = valid_q;
    if (stage_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_pop_o) begin
      valid_d = 1'b1;
      case (cmd_i.op)
        OP_LOAD: begin
          state_d = hs;
        end
        OP_UPDATE: begin
          state_d = sum_w[20:0];
        end
        default: begin
          state_d = state_q;
        end
      endcase
      stage_d.hv = cmd_i.op != OP_SKIP;
      stage_d.st = state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_valid_o = valid_q;
  assign stage_o       = stage_q;

endmodule

FILE: src/chs_out.sv
module chs_out import chs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  chs_cfg_t   cfg_i,
  input  logic       stage_valid_i,
  output logic       stage_ready_o,
  input  chs_stage_t stage_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output chs_out_t   out_item_o
);

  localparam logic signed [14:0] FullT = 15'(FullIn);

  logic               valid_q, valid_d;
  chs_out_t           item_q, item_d;
  logic [21:0]        st_rnd;
  logic [13:0]        mag14;
  logic [12:0]        mag;
  logic signed [14:0] tsum;
  logic [12:0]        tru;
  logic               tv, st_true;
  logic [12:0]        shown;
  logic [2:0]         sect;

  assign stage_ready_o = ~valid_q | out_ready_i;

  assign st_rnd = {1'b0, stage_i.st} + 22'd128;
  assign mag14  = st_rnd[21:8];
  assign mag    = (mag14 == 14'(FullIn)) ? 13'd0 : mag14[12:0];
  assign tsum   = $signed({2'b00, mag}) + $signed({{2{cfg_i.decl[12]}}, cfg_i.decl});

  always_comb begin
    tv      = cfg_i.decl_valid;
    st_true = cfg_i.view_true & tv;
    if (!tv) begin
      tru = '0;
    end else if (tsum < 0) begin
      tru = 13'(tsum + FullT);
    end else if (tsum >= FullT) begin
      tru = 13'(tsum - FullT);
    end else begin
      tru = tsum[12:0];
    end
    shown = st_true ? tru : mag;
  end

  // sectors are centred on the points, so north straddles the wrap
  always_comb begin
    sect = '0;
    for (int k = 1; k < 8; k++) begin
      if (shown >= 13'(k * SectSpan - SectHalf)) begin
        sect = sect + 3'd1;
      end
    end
    if (shown >= 13'(8 * SectSpan - SectHalf)) begin
      sect = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (stage_valid_i && stage_ready_o) begin
      valid_d = 1'b1;
      if (stage_i.hv) begin
        item_d.heading_valid = 1'b1;
        item_d.smoothed_mag  = mag;
        item_d.geo_heading   = tru;
        item_d.true_valid    = tv;
        item_d.shown_heading = shown;
        item_d.shown_is_true = st_true;
        item_d.sector        = sect;
      end else begin
        item_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: src/compass_heading_smoother_unit.sv
// Compass heading smoother.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes one magnetic heading
// sample per item in 1/16 degree units with a sample-valid flag. Each item
// gives exactly one result item on the output channel (out_valid_o/
// out_ready_i, out_item_o): smoothed magnetic heading, true heading, the
// selected view and its 8-point compass sector. Invalid samples give an
// all-zero result and leave the average alone.
// Configuration (declination, declination valid, view select, Q16 gain) is
// written through cfg_valid_i/cfg_ready_o with cfg_index_i/cfg_data_i;
// cfg_ready_o is always high. The user must write it only while the block is
// idle; the block itself does not enforce this. Throughput is one item per
// cycle while out_ready_i is high, bounded by the combinational
// difference-multiply-add loop on the smoothed state in the back end.
// Reset empties the queue and pipeline, clears the average (next valid sample
// seeds it) and loads the register defaults. When the receiver stalls, the
// output register holds, the pipeline fills and the command queue
// (QueueDepth items) absorbs accepted items before in_ready_o drops.
module compass_heading_smoother_unit import chs_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  chs_in_t     in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output chs_out_t    out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  chs_cfg_t   cfg_q, cfg_d;
  logic       push, push_ready, cmd_valid, cmd_pop;
  chs_cmd_t   push_cmd, cmd;
  logic       stage_valid, stage_ready;
  chs_stage_t stage;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (chs_cfg_idx_e'(cfg_index_i))
        CFG_DECL:       cfg_d.decl       = $signed(cfg_data_i[12:0]);
        CFG_DECL_VALID: cfg_d.decl_valid = cfg_data_i[0];
        CFG_VIEW_TRUE:  cfg_d.view_true  = cfg_data_i[0];
        CFG_GAIN:       cfg_d.gain       = cfg_data_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decl       <= '0;
      cfg_q.decl_valid <= 1'b0;
      cfg_q.view_true  <= 1'b0;
      cfg_q.gain       <= GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  chs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  chs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_i        (cmd_pop),
    .pop_data_o   (cmd)
  );

  chs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .cmd_i         (cmd),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_o       (stage)
  );

  chs_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .stage_valid_i (stage_valid),
    .stage_ready_o (stage_ready),
    .stage_i       (stage),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

endmodule
